// ----- design/kiwi_drive_motor_command_top_assert.svh -----
// Assertion macros for the kiwi drive motor command block.
`ifndef KIWI_DRIVE_MOTOR_COMMAND_TOP_ASSERT_SVH
`define KIWI_DRIVE_MOTOR_COMMAND_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define KDMC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kdmc: same-cycle check failed");
`define KDMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kdmc: next-cycle check failed");
`else
`define KDMC_ASSERT_SAME(lbl, ante, cons)
`define KDMC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/kdmc_pkg.sv -----
// Types, constants and microcode table of the kiwi drive motor command block.
package kdmc_pkg;

  // Input and result transactions.
  typedef struct packed {
    logic              op;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_rot;
    logic              stop_pressed;
    logic              enable_pressed;
  } in_item_t;

  typedef struct packed {
    logic        motor_enable;
    logic [2:0]  dir_bits;
    logic [15:0] duty_one;
    logic [15:0] duty_two;
    logic [15:0] duty_three;
    logic [2:0]  overspeed_bits;
    logic [2:0]  duty_error_bits;
  } out_item_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAX_RPM    = 3'd0;
  localparam logic [2:0] REG_MIN_DUTY   = 3'd1;
  localparam logic [2:0] REG_MAX_DUTY   = 3'd2;
  localparam logic [2:0] REG_INVERT_X   = 3'd3;
  localparam logic [2:0] REG_INVERT_Y   = 3'd4;
  localparam logic [2:0] REG_INVERT_ROT = 3'd5;

  // Input operation codes.
  localparam logic OP_VELOCITY = 1'b0;
  localparam logic OP_BUTTON   = 1'b1;

  // Q16 kinematic coefficients, motor RPM per input LSB.
  localparam logic signed [17:0] COEF_FULL = 18'sd72227;
  localparam logic signed [17:0] COEF_HALF = 18'sd36114;
  localparam logic signed [17:0] COEF_SQRT = 18'sd62551;
  localparam logic signed [17:0] COEF_DIST = 18'sd11556;
  localparam logic [14:0] RPM_LIMIT = 15'd32767;

  localparam logic [1:0] MOTOR_LAST = 2'd2;

  // Divider handshake from the sequencer.
  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // Microprogram steps.
  typedef logic [3:0] step_t;
  localparam step_t S_DISPATCH = 4'd0;
  localparam step_t S_MUL_X    = 4'd1;
  localparam step_t S_MUL_Y    = 4'd2;
  localparam step_t S_MUL_W    = 4'd3;
  localparam step_t S_ACC      = 4'd4;
  localparam step_t S_RPM      = 4'd5;
  localparam step_t S_CHECK    = 4'd6;
  localparam step_t S_MUL_SPAN = 4'd7;
  localparam step_t S_LOAD     = 4'd8;
  localparam step_t S_DIV      = 4'd9;
  localparam step_t S_WRITE    = 4'd10;
  localparam step_t S_NEXT     = 4'd11;
  localparam step_t S_DONE     = 4'd12;

  typedef enum logic [3:0] {
    U_DISPATCH, U_MUL_X, U_MUL_Y, U_MUL_W, U_ACC, U_RPM, U_CHECK,
    U_MUL_SPAN, U_LOAD, U_DIV, U_WRITE, U_NEXT, U_DONE
  } uop_t;

  typedef enum logic [2:0] {
    C_NEXT, C_SKIP, C_NO_DUTY, C_ZERO_MAG, C_DIV_MORE, C_MORE_MOTORS, C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Control store: one word per step.
  function automatic ctrl_word_t ucode(input step_t pc);
    ctrl_word_t w;
    case (pc)
      S_DISPATCH: w = '{U_DISPATCH, C_SKIP,        S_DONE};
      S_MUL_X:    w = '{U_MUL_X,    C_NEXT,        S_MUL_X};
      S_MUL_Y:    w = '{U_MUL_Y,    C_NEXT,        S_MUL_X};
      S_MUL_W:    w = '{U_MUL_W,    C_NEXT,        S_MUL_X};
      S_ACC:      w = '{U_ACC,      C_NEXT,        S_MUL_X};
      S_RPM:      w = '{U_RPM,      C_NEXT,        S_MUL_X};
      S_CHECK:    w = '{U_CHECK,    C_NO_DUTY,     S_NEXT};
      S_MUL_SPAN: w = '{U_MUL_SPAN, C_NEXT,        S_MUL_X};
      S_LOAD:     w = '{U_LOAD,     C_ZERO_MAG,    S_WRITE};
      S_DIV:      w = '{U_DIV,      C_DIV_MORE,    S_DIV};
      S_WRITE:    w = '{U_WRITE,    C_NEXT,        S_MUL_X};
      S_NEXT:     w = '{U_NEXT,     C_MORE_MOTORS, S_MUL_X};
      S_DONE:     w = '{U_DONE,     C_OUT_BUSY,    S_DONE};
      default:    w = '{U_DONE,     C_OUT_BUSY,    S_DONE};
    endcase
    return w;
  endfunction

  // Per-motor coefficients of x and y.
  function automatic logic signed [17:0] coef_x(input logic [1:0] m);
    logic signed [17:0] c;
    case (m)
      MOTOR_LAST: c = COEF_FULL;
      default:    c = -COEF_HALF;
    endcase
    return c;
  endfunction

  function automatic logic signed [17:0] coef_y(input logic [1:0] m);
    logic signed [17:0] c;
    case (m)
      2'd0:       c = COEF_SQRT;
      2'd1:       c = -COEF_SQRT;
      default:    c = 18'sd0;
    endcase
    return c;
  endfunction

endpackage

// ----- design/kdmc_div.sv -----
// Restoring serial divider, one quotient bit per step, for the duty scaling.
module kdmc_div
  import kdmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_ctl_t    ctl,
  input  logic [30:0] dividend,
  input  logic [15:0] divisor,
  output logic [15:0] quotient,
  output logic        last
);

  logic [15:0] rem_r, rem_nxt;
  logic [15:0] quot_r, quot_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [16:0] rem_shift;
  logic [16:0] rem_diff;

  // The quotient fits in 16 bits because the upper dividend part stays below the divisor.
  always_comb begin
    rem_shift = {rem_r, quot_r[15]};
    rem_diff  = rem_shift - {1'b0, divisor};
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    cnt_nxt   = cnt_r;
    if (ctl.load) begin
      rem_nxt  = {1'b0, dividend[30:16]};
      quot_nxt = dividend[15:0];
      cnt_nxt  = '0;
    end else if (ctl.step) begin
      cnt_nxt = cnt_r + 4'd1;
      if (rem_shift >= {1'b0, divisor}) begin
        rem_nxt  = rem_diff[15:0];
        quot_nxt = {quot_r[14:0], 1'b1};
      end else begin
        rem_nxt  = rem_shift[15:0];
        quot_nxt = {quot_r[14:0], 1'b0};
      end
    end
  end

  // Only the step count is control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign quotient = quot_r;
  assign last     = (cnt_r == 4'd15);

endmodule

// ----- design/kiwi_drive_motor_command_top.sv -----
// Top level of the kiwi drive motor command block: microcoded sequencer and datapath.
//
// Input channel in_valid / in_stall / in_data carries one velocity command or button
// sample per transaction; result channel out_valid / out_stall / out_data returns one
// result transaction per input. A transaction moves on a rising edge with valid high
// and stall low. The cfg_we / cfg_index / cfg_wdata port writes one register per edge.
// A button item or an item seen with the run latch clear goes from the dispatch step
// straight to the final step. For a velocity item the sequencer runs up to 26 steps per
// motor over one shared 18x17 multiplier and a 16-step serial divider, three motors in
// turn. A motor that is over speed or has a bad duty range ends after 7 steps, and one
// at zero speed skips the divider and ends after 10. One item is in work at a time; the
// next is accepted the cycle after the previous result is loaded into the output
// register.
// A stalled result stays in the output register; the sequencer then waits on its final
// step and holds in_stall high until the result is taken.
// Synchronous reset loads the register defaults (6000, 0, 255, no inversion), sets the
// run latch, clears the enable line, directions and duties, and empties the output.
module kiwi_drive_motor_command_top
  import kdmc_pkg::*;
#(
  parameter int PWM_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam logic [16:0] DUTY_LIMIT = 17'((32'd1 << PWM_BITS) - 32'd1);

  // Configuration registers.
  logic [15:0] max_rpm_r, max_rpm_nxt;
  logic [15:0] min_duty_r, min_duty_nxt;
  logic [15:0] max_duty_r, max_duty_nxt;
  logic        inv_x_r, inv_x_nxt;
  logic        inv_y_r, inv_y_nxt;
  logic        inv_rot_r, inv_rot_nxt;

  // Block state.
  logic        run_latch_r, run_latch_nxt;
  logic        enable_r, enable_nxt;
  logic [2:0]  dir_r, dir_nxt;
  logic [15:0] duty_r [3];
  logic [15:0] duty_nxt [3];
  logic [2:0]  over_r, over_nxt;
  logic [2:0]  derr_r, derr_nxt;

  // Sequencer.
  logic        busy_r, busy_nxt;
  step_t       pc_r, pc_nxt;
  logic [1:0]  m_r, m_nxt;
  ctrl_word_t  cw;
  logic        jump;

  // Held item.
  logic               op_r, op_nxt;
  logic               stop_r, stop_nxt;
  logic               enbtn_r, enbtn_nxt;
  logic               nz_r, nz_nxt;
  logic signed [16:0] x_r, x_nxt;
  logic signed [16:0] y_r, y_nxt;
  logic signed [16:0] w_r, w_nxt;

  // Datapath.
  logic signed [17:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [34:0] prod_r, prod_nxt;
  logic signed [35:0] acc_r, acc_nxt;
  logic [14:0]        mag_r, mag_nxt;
  logic [35:0]        acc_abs;
  logic [19:0]        mag_full;
  logic [15:0]        span;
  logic [16:0]        duty_sum;
  logic               no_duty;
  logic signed [16:0] ext_x, ext_y, ext_w;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Divider.
  div_ctl_t    div_ctl;
  logic [15:0] quotient;
  logic        div_last;

  kdmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (prod_r[30:0]),
    .divisor  (max_rpm_r),
    .quotient (quotient),
    .last     (div_last)
  );

  assign cw       = ucode(pc_r);
  assign span     = max_duty_r - min_duty_r;
  assign acc_abs  = acc_r[35] ? 36'(-acc_r) : 36'(acc_r);
  assign mag_full = acc_abs[35:16];
  assign duty_sum = {1'b0, min_duty_r} + {1'b0, quotient};
  assign no_duty  = ({1'b0, mag_r} > max_rpm_r) || (min_duty_r > max_duty_r);
  assign ext_x    = {in_data.vel_x[15], in_data.vel_x};
  assign ext_y    = {in_data.vel_y[15], in_data.vel_y};
  assign ext_w    = {in_data.vel_rot[15], in_data.vel_rot};

  // Shared multiplier operand selection.
  always_comb begin
    case (cw.op)
      U_MUL_X:    begin mul_a = coef_x(m_r); mul_b = x_r; end
      U_MUL_Y:    begin mul_a = coef_y(m_r); mul_b = y_r; end
      U_MUL_W:    begin mul_a = COEF_DIST;   mul_b = w_r; end
      U_MUL_SPAN: begin mul_a = {3'b000, mag_r}; mul_b = {1'b0, span}; end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Jump condition of the current control word.
  always_comb begin
    case (cw.cond)
      C_NEXT:        jump = 1'b0;
      C_SKIP:        jump = (op_r == OP_BUTTON) || !run_latch_r;
      C_NO_DUTY:     jump = no_duty;
      C_ZERO_MAG:    jump = (mag_r == '0);
      C_DIV_MORE:    jump = !div_last;
      C_MORE_MOTORS: jump = (m_r != MOTOR_LAST);
      C_OUT_BUSY:    jump = out_valid_r && out_stall;
      default:       jump = 1'b0;
    endcase
  end

  // Next state of sequencer, datapath and registers.
  always_comb begin
    max_rpm_nxt   = max_rpm_r;
    min_duty_nxt  = min_duty_r;
    max_duty_nxt  = max_duty_r;
    inv_x_nxt     = inv_x_r;
    inv_y_nxt     = inv_y_r;
    inv_rot_nxt   = inv_rot_r;
    run_latch_nxt = run_latch_r;
    enable_nxt    = enable_r;
    dir_nxt       = dir_r;
    duty_nxt      = duty_r;
    over_nxt      = over_r;
    derr_nxt      = derr_r;
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    m_nxt         = m_r;
    op_nxt        = op_r;
    stop_nxt      = stop_r;
    enbtn_nxt     = enbtn_r;
    nz_nxt        = nz_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    acc_nxt       = acc_r;
    mag_nxt       = mag_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_ctl       = '0;

    // The user must make configuration writes only while idle; the block does not enforce it.
    if (cfg_we) begin
      case (cfg_index)
        REG_MAX_RPM:    max_rpm_nxt  = cfg_wdata;
        REG_MIN_DUTY:   min_duty_nxt = cfg_wdata;
        REG_MAX_DUTY:   max_duty_nxt = cfg_wdata;
        REG_INVERT_X:   inv_x_nxt    = cfg_wdata[0];
        REG_INVERT_Y:   inv_y_nxt    = cfg_wdata[0];
        REG_INVERT_ROT: inv_rot_nxt  = cfg_wdata[0];
        default: ;
      endcase
    end

    // The receiver takes the result.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (!busy_r) begin
      // Capture a new item, applying the axis inversions.
      if (in_valid) begin
        busy_nxt  = 1'b1;
        pc_nxt    = S_DISPATCH;
        op_nxt    = in_data.op;
        stop_nxt  = in_data.stop_pressed;
        enbtn_nxt = in_data.enable_pressed;
        nz_nxt    = (in_data.vel_x != '0) || (in_data.vel_y != '0) ||
                    (in_data.vel_rot != '0);
        x_nxt     = inv_x_r   ? -ext_x : ext_x;
        y_nxt     = inv_y_r   ? -ext_y : ext_y;
        w_nxt     = inv_rot_r ? -ext_w : ext_w;
      end
    end else begin
      pc_nxt = jump ? cw.target : step_t'(pc_r + 4'd1);
      case (cw.op)
        U_DISPATCH: begin
          over_nxt = '0;
          derr_nxt = '0;
          m_nxt    = '0;
          if (op_r == OP_BUTTON) begin
            if (stop_r) begin
              run_latch_nxt = 1'b0;
              enable_nxt    = 1'b0;
            end
            if (enbtn_r) begin
              run_latch_nxt = 1'b1;
            end
          end else if (!run_latch_r) begin
            enable_nxt = 1'b0;
          end else if (nz_r) begin
            enable_nxt = 1'b1;
          end
        end
        U_MUL_Y: acc_nxt = 36'(prod_r);
        U_MUL_W: acc_nxt = acc_r + 36'(prod_r);
        U_ACC:   acc_nxt = acc_r + 36'(prod_r);
        // Truncate toward zero, saturate, and take the direction.
        U_RPM: begin
          mag_nxt = (mag_full > {5'd0, RPM_LIMIT}) ? RPM_LIMIT : mag_full[14:0];
          dir_nxt[m_r] = !(acc_r[35] && (mag_full != '0));
        end
        // Over-speed wins over a bad duty range.
        U_CHECK: begin
          if ({1'b0, mag_r} > max_rpm_r) begin
            over_nxt[m_r] = 1'b1;
          end else if (min_duty_r > max_duty_r) begin
            derr_nxt[m_r] = 1'b1;
          end
        end
        U_LOAD: div_ctl.load = 1'b1;
        U_DIV:  div_ctl.step = 1'b1;
        U_WRITE: begin
          if (duty_sum > DUTY_LIMIT) begin
            derr_nxt[m_r] = 1'b1;
          end else begin
            duty_nxt[m_r] = duty_sum[15:0];
          end
        end
        U_NEXT: begin
          if (m_r != MOTOR_LAST) begin
            m_nxt = m_r + 2'd1;
          end
        end
        U_DONE: begin
          if (!out_valid_r || !out_stall) begin
            busy_nxt      = 1'b0;
            out_valid_nxt = 1'b1;
            out_data_nxt.motor_enable    = enable_r;
            out_data_nxt.dir_bits        = dir_r;
            out_data_nxt.duty_one        = duty_r[0];
            out_data_nxt.duty_two        = duty_r[1];
            out_data_nxt.duty_three      = duty_r[2];
            out_data_nxt.overspeed_bits  = over_r;
            out_data_nxt.duty_error_bits = derr_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rpm_r   <= 16'd6000;
      min_duty_r  <= 16'd0;
      max_duty_r  <= 16'd255;
      inv_x_r     <= 1'b0;
      inv_y_r     <= 1'b0;
      inv_rot_r   <= 1'b0;
      run_latch_r <= 1'b1;
      enable_r    <= 1'b0;
      dir_r       <= '0;
      duty_r      <= '{default: '0};
      over_r      <= '0;
      derr_r      <= '0;
      busy_r      <= 1'b0;
      pc_r        <= S_DISPATCH;
      m_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      max_rpm_r   <= max_rpm_nxt;
      min_duty_r  <= min_duty_nxt;
      max_duty_r  <= max_duty_nxt;
      inv_x_r     <= inv_x_nxt;
      inv_y_r     <= inv_y_nxt;
      inv_rot_r   <= inv_rot_nxt;
      run_latch_r <= run_latch_nxt;
      enable_r    <= enable_nxt;
      dir_r       <= dir_nxt;
      duty_r      <= duty_nxt;
      over_r      <= over_nxt;
      derr_r      <= derr_nxt;
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      m_r         <= m_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    stop_r     <= stop_nxt;
    enbtn_r    <= enbtn_nxt;
    nz_r       <= nz_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    w_r        <= w_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    mag_r      <= mag_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "kiwi_drive_motor_command_top_assert.svh"

  // An accepted transaction starts the program at its dispatch step.
  `KDMC_ASSERT_NEXT(a_start_dispatch, in_valid && !in_stall, busy_r && (pc_r == S_DISPATCH))
  // A result appears only from the final step of the program.
  `KDMC_ASSERT_NEXT(a_load_from_done, !out_valid_r && !(busy_r && (pc_r == S_DONE)), !out_valid_r)
  // The motor index and step counter stay inside the program.
  `KDMC_ASSERT_SAME(a_motor_range, busy_r, (m_r <= MOTOR_LAST) && (pc_r <= S_DONE))
  // A motor is flagged for over-speed or a duty error, never both.
  `KDMC_ASSERT_SAME(a_flags_disjoint, 1'b1, (over_r & derr_r) == 3'b000)

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the kiwi drive motor command block.
`timescale 1ns / 1ps

module tb_top;
  import kdmc_pkg::*;

  localparam int PWM_WIDTH = 16;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int RAND_PER_PHASE = 153;
  localparam int DRAIN_CYCLES = 100;

  // Q16 wheel coefficients: motor RPM per input LSB.
  localparam longint Q16_FULL = 72227;
  localparam longint Q16_HALF = 36114;
  localparam longint Q16_SQRT = 62551;
  localparam longint Q16_DIST = 11556;
  localparam longint RPM_CAP = 32767;
  localparam longint DUTY_CEILING = (longint'(1) << PWM_WIDTH) - 1;

  // Register indexes that the block must ignore.
  localparam logic [2:0] NO_REG_LOW  = 3'd6;
  localparam logic [2:0] NO_REG_HIGH = 3'd7;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } steer_row_t;

  typedef struct {
    int max_rpm;
    int min_duty;
    int max_duty;
    bit flip_x;
    bit flip_y;
    bit flip_rot;
  } cfg_setting_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  int     idle_pct = 0;
  int     stall_pct = 0;
  bit     failed = 1'b0;
  longint cycle_count = 0;

  // Predictor copy of the registers and the block state.
  longint cmd_max_rpm = 6000;
  longint cmd_min_duty = 0;
  longint cmd_max_duty = 255;
  bit     flip_x = 1'b0;
  bit     flip_y = 1'b0;
  bit     flip_rot = 1'b0;
  bit          run_allowed = 1'b1;
  bit          enable_level = 1'b0;
  logic [2:0]  dir_state = '0;
  logic [15:0] duty_state [3] = '{16'd0, 16'd0, 16'd0};

  out_item_t motor_results_due [$];

  kiwi_drive_motor_command_top #(.PWM_BITS(PWM_WIDTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Q16 sum to a whole RPM, truncated toward zero and saturated.
  function automatic longint rpm_from_sum(input longint sum);
    longint r;
    r = sum / 65536;
    if (r > RPM_CAP) r = RPM_CAP;
    if (r < -RPM_CAP) r = -RPM_CAP;
    return r;
  endfunction

  // Mirror a register write into the predictor.
  function automatic void shadow_register(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      REG_MAX_RPM:    cmd_max_rpm = longint'(data);
      REG_MIN_DUTY:   cmd_min_duty = longint'(data);
      REG_MAX_DUTY:   cmd_max_duty = longint'(data);
      REG_INVERT_X:   flip_x = data[0];
      REG_INVERT_Y:   flip_y = data[0];
      REG_INVERT_ROT: flip_rot = data[0];
      default: ;
    endcase
  endfunction

  // Advance the predicted state by one input transaction and return its result.
  function automatic out_item_t drive_motors(input in_item_t item);
    out_item_t res;
    longint x, y, w, mag, duty;
    longint rpm [3];
    logic [2:0] over, derr;
    int i;
    over = '0;
    derr = '0;
    if (item.op == OP_BUTTON) begin
      if (item.stop_pressed) begin
        run_allowed = 1'b0;
        enable_level = 1'b0;
      end
      if (item.enable_pressed) run_allowed = 1'b1;
    end else if (!run_allowed) begin
      enable_level = 1'b0;
    end else begin
      x = longint'(item.vel_x);
      y = longint'(item.vel_y);
      w = longint'(item.vel_rot);
      if (x != 0 || y != 0 || w != 0) enable_level = 1'b1;
      if (flip_x) x = -x;
      if (flip_y) y = -y;
      if (flip_rot) w = -w;
      rpm[0] = rpm_from_sum(-Q16_HALF * x + Q16_SQRT * y + Q16_DIST * w);
      rpm[1] = rpm_from_sum(-Q16_HALF * x - Q16_SQRT * y + Q16_DIST * w);
      rpm[2] = rpm_from_sum(Q16_FULL * x + Q16_DIST * w);
      for (i = 0; i < 3; i++) begin
        mag = rpm[i];
        if (mag >= 0) begin
          dir_state[i] = 1'b1;
        end else begin
          dir_state[i] = 1'b0;
          mag = -mag;
        end
        // Over-speed wins over a duty error; either one holds the duty.
        if (mag > cmd_max_rpm) begin
          over[i] = 1'b1;
        end else if (cmd_min_duty > cmd_max_duty) begin
          derr[i] = 1'b1;
        end else begin
          duty = cmd_min_duty;
          if (mag > 0) duty += mag * (cmd_max_duty - cmd_min_duty) / cmd_max_rpm;
          if (duty > DUTY_CEILING) derr[i] = 1'b1;
          else duty_state[i] = duty[15:0];
        end
      end
    end
    res.motor_enable = enable_level;
    res.dir_bits = dir_state;
    res.duty_one = duty_state[0];
    res.duty_two = duty_state[1];
    res.duty_three = duty_state[2];
    res.overspeed_bits = over;
    res.duty_error_bits = derr;
    return res;
  endfunction

  // Hand-written result for directed rows; duties there are still at zero.
  function automatic out_item_t outcome(input bit en, input logic [2:0] dir,
                                        input logic [2:0] over);
    out_item_t r;
    r = '0;
    r.motor_enable = en;
    r.dir_bits = dir;
    r.overspeed_bits = over;
    return r;
  endfunction

  function automatic steer_row_t steer_row(input logic op, input logic [15:0] x,
                                           input logic [15:0] y, input logic [15:0] w,
                                           input bit stop, input bit ena,
                                           input bit typed, input out_item_t want);
    steer_row_t r;
    r.stim.op = op;
    r.stim.vel_x = x;
    r.stim.vel_y = y;
    r.stim.vel_rot = w;
    r.stim.stop_pressed = stop;
    r.stim.enable_pressed = ena;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Mostly speeds small enough to stay in range, with zeros and extremes mixed in.
  function automatic logic [15:0] random_speed();
    logic [15:0] v;
    int mag;
    case ($urandom_range(9))
      0, 1: v = '0;
      2, 3: v = 16'($urandom);
      8: begin
        case ($urandom_range(3))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'h0001;
          default: v = 16'hFFFF;
        endcase
      end
      9: begin
        mag = $urandom_range(300);
        v = 16'($urandom_range(1) ? -mag : mag);
      end
      default: begin
        mag = $urandom_range(4000);
        v = 16'($urandom_range(1) ? -mag : mag);
      end
    endcase
    return v;
  endfunction

  function automatic in_item_t random_command();
    in_item_t it;
    it.op = ($urandom_range(99) < 12) ? OP_BUTTON : OP_VELOCITY;
    it.vel_x = random_speed();
    it.vel_y = random_speed();
    it.vel_rot = random_speed();
    it.stop_pressed = ($urandom_range(3) == 0);
    it.enable_pressed = 1'($urandom_range(1));
    return it;
  endfunction

  // Present one transaction, wait for it to be taken, and queue its result.
  task automatic send_command(input in_item_t item, input bit typed, input out_item_t want);
    logic [63:0] junk;
    out_item_t predicted;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      junk = {$urandom, $urandom};
      in_valid <= 1'b0;
      in_data <= junk[$bits(in_item_t)-1:0];
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = drive_motors(item);
    motor_results_due.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    shadow_register(idx, data);
  endtask

  // Let every outstanding result drain, then give the block time to settle.
  task automatic wait_idle();
    while (motor_results_due.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Receiver stall, drawn fresh every cycle.
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Compare each result transaction against the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (motor_results_due.size() == 0) begin
        $error("result transaction with no expectation pending: %p", out_data);
        failed = 1'b1;
      end else begin
        want = motor_results_due.pop_front();
        check_field("motor_enable", 16'(want.motor_enable), 16'(out_data.motor_enable));
        check_field("dir_bits", 16'(want.dir_bits), 16'(out_data.dir_bits));
        check_field("duty_one", want.duty_one, out_data.duty_one);
        check_field("duty_two", want.duty_two, out_data.duty_two);
        check_field("duty_three", want.duty_three, out_data.duty_three);
        check_field("overspeed_bits", 16'(want.overspeed_bits),
                    16'(out_data.overspeed_bits));
        check_field("duty_error_bits", 16'(want.duty_error_bits),
                    16'(out_data.duty_error_bits));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    steer_row_t   rows [$];
    cfg_setting_t settings [$];
    cfg_setting_t s;
    int p, n;

    // Directed rows, run with the reset register values.
    rows.push_back(steer_row(OP_VELOCITY, 16'h0000, 16'h0000, 16'h0000, 0, 0, 1,
                             outcome(0, 3'b111, 3'b000)));
    rows.push_back(steer_row(OP_VELOCITY, 16'h7FFF, 16'h0000, 16'h0000, 1, 1, 1,
                             outcome(1, 3'b100, 3'b111)));
    rows.push_back(steer_row(OP_VELOCITY, 16'h8000, 16'h0000, 16'h0000, 0, 0, 1,
                             outcome(1, 3'b011, 3'b111)));
    rows.push_back(steer_row(OP_VELOCITY, 16'h0000, 16'h7FFF, 16'h0000, 0, 1, 1,
                             outcome(1, 3'b101, 3'b011)));
    // Stop clears the latch; a velocity command then only drops the enable line.
    rows.push_back(steer_row(OP_BUTTON, 16'h7FFF, 16'h8000, 16'h1234, 1, 0, 1,
                             outcome(0, 3'b101, 3'b000)));
    rows.push_back(steer_row(OP_VELOCITY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 1,
                             outcome(0, 3'b101, 3'b000)));
    // Both buttons: latch set again, line stays low.
    rows.push_back(steer_row(OP_BUTTON, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1,
                             outcome(0, 3'b101, 3'b000)));
    // A zero command leaves the enable line alone but still sets directions.
    rows.push_back(steer_row(OP_VELOCITY, 16'h0000, 16'h0000, 16'h0000, 1, 0, 1,
                             outcome(0, 3'b111, 3'b000)));
    rows.push_back(steer_row(OP_BUTTON, 16'h0000, 16'h0000, 16'h0000, 0, 0, 1,
                             outcome(0, 3'b111, 3'b000)));
    rows.push_back(steer_row(OP_BUTTON, 16'h5A5A, 16'hA5A5, 16'h0F0F, 0, 1, 1,
                             outcome(0, 3'b111, 3'b000)));
    rows.push_back(steer_row(OP_VELOCITY, 16'h0000, 16'h8000, 16'h0000, 0, 0, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, 16'h0000, 16'h0000, 16'h7FFF, 0, 0, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, 16'h0000, 16'h0000, 16'h8000, 0, 0, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, 16'h0001, 16'h0000, 16'h0000, 0, 0, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, 16'hFFFF, 16'h0000, 16'h0000, 0, 0, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, 16'h0000, 16'h0001, 16'h0000, 0, 0, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, 16'h0000, 16'h0000, 16'hFFFF, 0, 0, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, 16'h8000, 16'h8000, 16'h8000, 1, 1, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, 16'd100, -16'sd200, 16'd300, 0, 0, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, -16'sd1500, 16'd2500, -16'sd4000, 0, 0, 0, '0));
    rows.push_back(steer_row(OP_BUTTON, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, 16'd500, 16'd500, 16'd500, 0, 0, 0, '0));
    rows.push_back(steer_row(OP_BUTTON, 16'h0000, 16'h0000, 16'h0000, 0, 1, 0, '0));
    rows.push_back(steer_row(OP_VELOCITY, 16'd4000, -16'sd3000, 16'd1200, 0, 0, 0, '0));

    // Register settings, one per random phase, extremes among them.
    settings.push_back('{6000, 0, 255, 0, 0, 0});
    settings.push_back('{65535, 0, 65535, 1, 1, 1});
    settings.push_back('{1, 100, 200, 0, 1, 0});
    settings.push_back('{0, 7, 9, 0, 0, 1});
    settings.push_back('{3000, 500, 100, 1, 0, 0});
    settings.push_back('{20000, 65535, 65535, 0, 1, 1});
    settings.push_back('{32767, 1000, 60000, 1, 0, 1});
    settings.push_back('{12000, 0, 1023, 0, 0, 0});

    // Synchronous reset, released on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_command(rows[i].stim, rows[i].typed, rows[i].want);

    for (p = 0; p < settings.size(); p++) begin
      in_valid <= 1'b0;
      wait_idle();
      s = settings[p];
      write_register(REG_MAX_RPM, 16'(s.max_rpm));
      write_register(REG_MIN_DUTY, 16'(s.min_duty));
      write_register(REG_MAX_DUTY, 16'(s.max_duty));
      write_register(REG_INVERT_X, {15'd0, s.flip_x});
      write_register(REG_INVERT_Y, {15'd0, s.flip_y});
      write_register(REG_INVERT_ROT, {15'd0, s.flip_rot});
      write_register(p[0] ? NO_REG_HIGH : NO_REG_LOW, 16'($urandom));
      @(negedge clk);
      cfg_we <= 1'b0;
      // Idling pattern: none, sender gaps, receiver stalls, light on both.
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      for (n = 0; n < RAND_PER_PHASE; n++) send_command(random_command(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (motor_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && motor_results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
